/* hw/rtl/flcc_pkg.sv */
// Shared types and constants for the frame length / checksum checker.
// No dependencies; imported by flcc_frame_fsm, frame_length_checksum_checker and the testbench.
package flcc_pkg;

  // Frame layout
  localparam logic [7:0]  START_BYTE  = 8'h01;
  localparam int unsigned HEADER_LEN  = 5;
  localparam int unsigned LEN_LO_POS  = 3;
  localparam int unsigned LEN_HI_POS  = 4;
  localparam int unsigned SEEN_W      = 17;

  // Per-beat status codes
  typedef enum logic [1:0] {
    ST_INCOMPLETE  = 2'd0,
    ST_COMPLETE    = 2'd1,
    ST_WRONG_START = 2'd2,
    ST_CKSUM_ERR   = 2'd3
  } status_t;

  // Frame parser phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CKLO    = 5'b01000,
    PH_CKHI    = 5'b10000
  } phase_t;

  // One result beat
  typedef struct packed {
    status_t     status;
    logic [15:0] computed_sum;
    logic [15:0] payload_length;
  } flcc_result_t;

endpackage

/* hw/rtl/flcc_frame_fsm.sv */
// Frame parser state machine: phase, byte count, length, running sum.
// Depends on flcc_pkg. Computes one result per stepped byte.
module flcc_frame_fsm
  import flcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   rx_byte,
  input  logic         restart,
  output flcc_result_t result
);

  phase_t              phase_r, phase_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [15:0]         sum_r, sum_nxt;
  logic [7:0]          low_r, low_nxt;

  phase_t              cur_phase;
  logic [SEEN_W-1:0]   cur_seen, seen_inc;
  logic [15:0]         cur_len, cur_sum;
  logic [7:0]          cur_low;
  logic                clr, phase_ok, final_beat;
  status_t             st;
  logic [15:0]         sum_add;

  // Restart or an unused phase code drops the frame before this byte
  assign phase_ok = (phase_r == PH_IDLE) || (phase_r == PH_HEADER) ||
                    (phase_r == PH_PAYLOAD) || (phase_r == PH_CKLO) ||
                    (phase_r == PH_CKHI);
  assign clr = restart || !phase_ok;

  assign cur_phase = clr ? PH_IDLE : phase_r;
  assign cur_seen  = clr ? '0 : seen_r;
  assign cur_len   = clr ? '0 : len_r;
  assign cur_sum   = clr ? '0 : sum_r;
  assign cur_low   = clr ? '0 : low_r;

  assign seen_inc = cur_seen + SEEN_W'(1);
  assign sum_add  = cur_sum + {8'd0, rx_byte};

  // Per-byte frame parsing
  always_comb begin
    st        = ST_INCOMPLETE;
    phase_nxt = cur_phase;
    seen_nxt  = cur_seen;
    len_nxt   = cur_len;
    sum_nxt   = cur_sum;
    low_nxt   = cur_low;
    unique case (cur_phase)
      PH_IDLE: begin
        if (rx_byte != START_BYTE) begin
          st = ST_WRONG_START;
        end else begin
          sum_nxt   = {8'd0, rx_byte};
          seen_nxt  = SEEN_W'(1);
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        sum_nxt  = sum_add;
        seen_nxt = seen_inc;
        if (cur_seen == SEEN_W'(LEN_LO_POS)) begin
          len_nxt = {8'd0, rx_byte};
        end else if (cur_seen == SEEN_W'(LEN_HI_POS)) begin
          len_nxt = {rx_byte, cur_len[7:0]};
        end
        if (seen_inc >= SEEN_W'(HEADER_LEN)) begin
          phase_nxt = (len_nxt == 16'd0) ? PH_CKLO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt  = sum_add;
        seen_nxt = seen_inc;
        if (seen_inc >= (SEEN_W'(HEADER_LEN) + {1'b0, cur_len})) begin
          phase_nxt = PH_CKLO;
        end
      end
      PH_CKLO: begin
        low_nxt   = rx_byte;
        seen_nxt  = seen_inc;
        phase_nxt = PH_CKHI;
      end
      PH_CKHI: begin
        st = ({rx_byte, cur_low} == cur_sum) ? ST_COMPLETE : ST_CKSUM_ERR;
      end
      default: begin
        st = ST_INCOMPLETE;
      end
    endcase
  end

  // Result fields; length shows once the frame is past its header
  always_comb begin
    result.status         = st;
    result.computed_sum   = sum_nxt;
    result.payload_length = ((phase_nxt == PH_PAYLOAD) || (phase_nxt == PH_CKLO) ||
                             (phase_nxt == PH_CKHI)) ? len_nxt : 16'd0;
    if (st == ST_WRONG_START) begin
      result.computed_sum   = 16'd0;
      result.payload_length = 16'd0;
    end
  end

  assign final_beat = (st == ST_COMPLETE) || (st == ST_CKSUM_ERR);

  // State update; a final status returns everything to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seen_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      low_r   <= '0;
    end else if (step_en) begin
      if (final_beat) begin
        phase_r <= PH_IDLE;
        seen_r  <= '0;
        len_r   <= '0;
        sum_r   <= '0;
        low_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        seen_r  <= seen_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        low_r   <= low_nxt;
      end
    end
  end

endmodule

/* hw/rtl/frame_length_checksum_checker.sv */
// Top level of the frame length / checksum checker: input and result registers.
// Depends on flcc_pkg and flcc_frame_fsm.

// Checks length-prefixed frames (start byte 0x01, 5-byte header with a
// little-endian payload length in bytes 3 and 4, payload, 16-bit additive
// checksum low byte first) and returns one status beat per received byte.
// Throughput is one byte per cycle while out_stall is low; an accepted input
// beat reaches its result beat through the input register, then the parser
// logic into the result register. in_stall rises only when both the input
// register and the result register are full and out_stall is high.
module frame_length_checksum_checker
  import flcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_computed_sum,
  output logic [15:0] out_payload_length
);

  logic         in_valid_r;
  logic [7:0]   rx_byte_r;
  logic         restart_r;
  logic         out_valid_r;
  flcc_result_t res_r;
  flcc_result_t res;
  logic         res_free, step_en, in_take;

  assign res_free = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && res_free;
  assign in_stall = in_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rx_byte_r <= in_rx_byte;
      restart_r <= in_restart;
    end
  end

  flcc_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (rx_byte_r),
    .restart (restart_r),
    .result  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_computed_sum   = res_r.computed_sum;
  assign out_payload_length = res_r.payload_length;

endmodule

/* sim/tb_frame_length_checksum_checker.sv */
// Self-checking testbench for frame_length_checksum_checker: frames, bad start
// bytes, checksum errors, restarts and back-pressure. Needs flcc_pkg and the RTL.
module tb_frame_length_checksum_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import flcc_pkg::*;

  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_computed_sum;
  logic [15:0] out_payload_length;

  frame_length_checksum_checker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_computed_sum   (out_computed_sum),
    .out_payload_length (out_payload_length)
  );

  // Parser state mirrored by the predictor
  phase_t      fr_phase = PH_IDLE;
  logic [16:0] fr_seen = '0;
  logic [15:0] fr_len = '0;
  logic [15:0] fr_sum = '0;
  logic [7:0]  fr_ck_lo = '0;

  flcc_result_t pending_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int n_complete = 0;
  int n_cksum_err = 0;
  int n_wrong_start = 0;
  int in_held_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_frame_length_checksum_checker failed");
    $finish;
  end

  function automatic void clear_frame();
    fr_phase = PH_IDLE;
    fr_seen  = '0;
    fr_len   = '0;
    fr_sum   = '0;
    fr_ck_lo = '0;
  endfunction

  // Advance the mirrored parser by one byte and return the status beat it gives
  function automatic flcc_result_t parse_byte(logic [7:0] b, logic rs);
    flcc_result_t res;
    status_t      st;
    st = ST_INCOMPLETE;
    if (rs)
      clear_frame();
    case (fr_phase)
      PH_HEADER: begin
        fr_sum = fr_sum + 16'(b);
        if (fr_seen == LEN_LO_POS)
          fr_len = {8'h00, b};
        else if (fr_seen == LEN_HI_POS)
          fr_len = {b, fr_len[7:0]};
        fr_seen = fr_seen + 17'd1;
        if (32'(fr_seen) >= HEADER_LEN)
          fr_phase = (fr_len == 16'd0) ? PH_CKLO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        fr_sum  = fr_sum + 16'(b);
        fr_seen = fr_seen + 17'd1;
        if (32'(fr_seen) >= HEADER_LEN + 32'(fr_len))
          fr_phase = PH_CKLO;
      end
      PH_CKLO: begin
        fr_ck_lo = b;
        fr_seen  = fr_seen + 17'd1;
        fr_phase = PH_CKHI;
      end
      PH_CKHI: begin
        st = ({b, fr_ck_lo} == fr_sum) ? ST_COMPLETE : ST_CKSUM_ERR;
      end
      default: begin
        // idle: only the start byte opens a frame
        if (b != START_BYTE) begin
          st = ST_WRONG_START;
        end else begin
          fr_sum   = 16'(b);
          fr_seen  = 17'd1;
          fr_phase = PH_HEADER;
        end
      end
    endcase
    res.status         = st;
    res.computed_sum   = fr_sum;
    res.payload_length = (fr_phase inside {PH_PAYLOAD, PH_CKLO, PH_CKHI}) ? fr_len : 16'd0;
    if (st == ST_WRONG_START) begin
      res.computed_sum   = 16'd0;
      res.payload_length = 16'd0;
    end
    if (st == ST_COMPLETE || st == ST_CKSUM_ERR)
      clear_frame();
    return res;
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (!rst_n)
      clear_frame();
    else if (in_valid && !in_stall)
      pending_results.push_back(parse_byte(in_rx_byte, in_restart));
    if (rst_n && in_valid && in_stall)
      in_held_cycles++;
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    flcc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d sum %h len %h",
                   out_status, out_computed_sum, out_payload_length);
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          ST_COMPLETE:    n_complete++;
          ST_CKSUM_ERR:   n_cksum_err++;
          ST_WRONG_START: n_wrong_start++;
          default:        ;
        endcase
        if (out_status != want.status || out_computed_sum != want.computed_sum ||
            out_payload_length != want.payload_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d sum %h len %h, got status %0d sum %h len %h",
                     results_checked, want.status, want.computed_sum, want.payload_length,
                     out_status, out_computed_sum, out_payload_length);
        end
      end
    end
  end

  // Result side stall: random, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one beat, starting and ending at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  // Build a frame with random header and payload; cut > 0 sends only its first bytes
  task automatic send_frame(input int unsigned plen, input int unsigned cut,
                            input bit bad_sum, input bit rs_first);
    logic [7:0]  fb[$];
    logic [15:0] fsum;
    logic [15:0] ck;
    int unsigned total;
    total = HEADER_LEN + plen + 2;
    if (cut == 0 || cut > total)
      cut = total;
    fb.push_back(START_BYTE);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(plen[7:0]);
    fb.push_back(plen[15:8]);
    for (int i = 0; i < plen && fb.size() < cut; i++)
      fb.push_back(8'($urandom));
    fsum = '0;
    foreach (fb[i])
      fsum = fsum + 16'(fb[i]);
    ck = bad_sum ? fsum ^ 16'($urandom_range(1, 65535)) : fsum;
    fb.push_back(ck[7:0]);
    fb.push_back(ck[15:8]);
    for (int i = 0; i < cut; i++)
      send_beat(fb[i], rs_first && i == 0);
  endtask

  // Stop offering and wait for every predicted beat to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic test_wrong_start();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h02, 1'b1);
    drain_results();
  endtask

  // Zero-length frames go straight from header to checksum
  task automatic test_zero_length();
    // good: sum 0x0180
    send_beat(8'h01, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b0);
    // bad: sum 0x0001, checksum all ones
    send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    drain_results();
  endtask

  // Restart drops a partial frame; a restart on a non-start byte is a bad start
  task automatic test_restart_mid_frame();
    send_beat(8'h01, 1'b0);
    send_beat(8'h55, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'h01, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'hAC, 1'b0);
    send_beat(8'h00, 1'b0);
    drain_results();
  endtask

  // Long result hold-off while the sender keeps offering a frame
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    send_frame(30, 0, 1'b0, 1'b0);
    drain_results();
  endtask

  // Mostly well-formed frames with random content, some cut short, some noise
  task automatic test_random_traffic(input int n_beats, input int tx_pct, input int rx_pct);
    int          target;
    int unsigned pick;
    int unsigned kind;
    int unsigned plen;
    int unsigned total;
    bit          need_restart;
    bit          rs;
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    target       = beats_sent + n_beats;
    need_restart = 1'b0;
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          send_beat(8'($urandom), 1'($urandom_range(1)));
        need_restart = 1'b1;
      end else begin
        if (pick < 92)
          plen = $urandom_range(8);
        else if (pick < 97)
          plen = $urandom_range(9, 40);
        else
          plen = $urandom_range(256, 300);
        rs   = need_restart || ($urandom_range(9) == 0);
        kind = $urandom_range(99);
        if (kind < 15) begin
          // abandoned frame, often with a wide length field
          if ($urandom_range(1))
            plen = $urandom_range(65535);
          total = HEADER_LEN + plen + 2;
          send_frame(plen, $urandom_range(1, (total > 40) ? 40 : total - 1), 1'b0, rs);
          need_restart = 1'b1;
        end else begin
          send_frame(plen, 0, kind < 30, rs);
          need_restart = 1'b0;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_wrong_start();
    test_zero_length();
    test_restart_mid_frame();
    test_backpressure();
    test_random_traffic(500, 9, 85);
    test_random_traffic(500, 85, 9);
    test_random_traffic(600, 0, 0);
    repeat (10) @(posedge clk);
    $display("Checked %0d byte beats: %0d frames good, %0d checksum errors, %0d bad starts",
             results_checked, n_complete, n_cksum_err, n_wrong_start);
    $display("Input was held off for %0d cycles by result back-pressure", in_held_cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_frame_length_checksum_checker passed");
    end else begin
      $display("tb_frame_length_checksum_checker failed");
    end
    $finish;
  end

endmodule

/* frame_length_checksum_checker.f */
hw/rtl/flcc_pkg.sv
hw/rtl/flcc_frame_fsm.sv
hw/rtl/frame_length_checksum_checker.sv
sim/tb_frame_length_checksum_checker.sv
